### src/pis_pkg.sv
// ----------------------------------------------------------------------------
// pis_pkg: shared types and constants for the PID with integral separation
// Configuration layout, register indexes and reset values.
// ----------------------------------------------------------------------------
package pis_pkg;

    localparam int GAIN_WIDTH      = 16;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int DRIVE_WIDTH     = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SEP_LIMIT  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DRIVE_MIN  = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DRIVE_MAX  = 3'd5;

    typedef struct packed {
        logic        [GAIN_WIDTH-1:0]  gain_p;
        logic        [GAIN_WIDTH-1:0]  gain_i;
        logic        [GAIN_WIDTH-1:0]  gain_d;
        logic        [GAIN_WIDTH-1:0]  separation_limit;
        logic signed [DRIVE_WIDTH-1:0] drive_min;
        logic signed [DRIVE_WIDTH-1:0] drive_max;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        gain_p:           16'd2048,
        gain_i:           16'd246,
        gain_d:           16'd205,
        separation_limit: 16'd15,
        drive_min:        -16'sd80,
        drive_max:        16'sd80
    };

endpackage

### src/pid_integral_separation.sv
// ----------------------------------------------------------------------------
// pid_integral_separation: positional PID controller with integral separation
// Stages: input register, error/integral, multipliers and sum/clamp,
// the last of which is the output register.
// Throughput: one word per cycle while the output is not stalled; the
// integral add-and-saturate feeds back on itself, which sets that figure.
// Reset: clears all valid flags, the previous error and the integral, and
// loads the default gains and limits.
// ----------------------------------------------------------------------------
module pid_integral_separation #(
    parameter int DATA_WIDTH     = 16,
    parameter int SUM_WIDTH      = 32,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic                                      clk,
    input  logic                                      rst_n,

    input  logic                                      cfg_we,
    input  logic [pis_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
    input  logic [pis_pkg::CFG_DATA_WIDTH-1:0]        cfg_data,

    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [DATA_WIDTH-1:0]              measured,
    input  logic signed [DATA_WIDTH-1:0]              setpoint,

    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [pis_pkg::DRIVE_WIDTH-1:0]    drive,
    output logic                                      clamped
);

    // Configuration registers. The user writes them only while the pipeline is empty; the block does not enforce it.
    pis_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= pis_pkg::CFG_RESET;
        else if (cfg_we)
        begin
            case (cfg_index)
                pis_pkg::REG_GAIN_P:    cfg_reg.gain_p           <= cfg_data;
                pis_pkg::REG_GAIN_I:    cfg_reg.gain_i           <= cfg_data;
                pis_pkg::REG_GAIN_D:    cfg_reg.gain_d           <= cfg_data;
                pis_pkg::REG_SEP_LIMIT: cfg_reg.separation_limit <= cfg_data;
                pis_pkg::REG_DRIVE_MIN: cfg_reg.drive_min        <= $signed(cfg_data);
                pis_pkg::REG_DRIVE_MAX: cfg_reg.drive_max        <= $signed(cfg_data);
                default:                ; // drop writes to unused indexes
            endcase
        end
    end

    // Pipeline valid flags. Each stage advances when it is empty or when the
    // stage after it moves on, so bubbles collapse and an input word can be
    // taken while a finished result still waits on the output, if a stage is free.
    logic valid0_reg;
    logic valid1_reg;
    logic valid2_reg;
    logic valid3_reg;
    logic ready0;
    logic ready1;
    logic ready2;
    logic ready3;
    logic in_accept;

    assign ready3    = !valid3_reg || !out_stall;
    assign ready2    = !valid2_reg || ready3;
    assign ready1    = !valid1_reg || ready2;
    assign ready0    = !valid0_reg || ready1;
    assign in_stall  = !ready0;
    assign in_accept = in_valid && ready0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
                valid0_reg <= in_valid;
            if (ready1)
                valid1_reg <= valid0_reg;
            if (ready2)
                valid2_reg <= valid1_reg;
            if (ready3)
                valid3_reg <= valid2_reg;
        end
    end

    // Stage 0/1: input register, error, derivative difference, integral.
    // The state advances only when a word moves into stage 1, so each
    // sample updates it exactly once and in order.
    logic signed [DATA_WIDTH:0]   err;
    logic signed [DATA_WIDTH+1:0] diff;
    logic signed [SUM_WIDTH-1:0]  error_sum;

    pis_error_stage #(
        .DATA_WIDTH (DATA_WIDTH),
        .SUM_WIDTH  (SUM_WIDTH)
    ) u_error (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_load          (in_accept),
        .calc_load        (valid0_reg && ready1),
        .measured         (measured),
        .setpoint         (setpoint),
        .gain_i           (cfg_reg.gain_i),
        .separation_limit (cfg_reg.separation_limit),
        .err              (err),
        .diff             (diff),
        .error_sum        (error_sum)
    );

    // Stage 2: the three gain products.
    logic signed [pis_pkg::GAIN_WIDTH+DATA_WIDTH+1:0] prod_p;
    logic signed [pis_pkg::GAIN_WIDTH+SUM_WIDTH:0]    prod_i;
    logic signed [pis_pkg::GAIN_WIDTH+DATA_WIDTH+2:0] prod_d;

    pis_mult_stage #(
        .DATA_WIDTH (DATA_WIDTH),
        .SUM_WIDTH  (SUM_WIDTH)
    ) u_mult (
        .clk       (clk),
        .load      (valid1_reg && ready2),
        .cfg       (cfg_reg),
        .err       (err),
        .diff      (diff),
        .error_sum (error_sum),
        .prod_p    (prod_p),
        .prod_i    (prod_i),
        .prod_d    (prod_d)
    );

    // Stage 3: sum, floor shift, clamp; this is the output register.
    pis_output_stage #(
        .DATA_WIDTH     (DATA_WIDTH),
        .SUM_WIDTH      (SUM_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_output (
        .clk     (clk),
        .load    (valid2_reg && ready3),
        .cfg     (cfg_reg),
        .prod_p  (prod_p),
        .prod_i  (prod_i),
        .prod_d  (prod_d),
        .drive   (drive),
        .clamped (clamped)
    );

    assign out_valid = valid3_reg;

    // A stalled output with a word behind it keeps both words.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid3_reg && out_stall && valid2_reg) |=> (valid3_reg && valid2_reg))
        else $error("pipeline lost a word under output stall");

    // A taken result with nothing behind it leaves the output empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid3_reg && !out_stall && !valid2_reg) |=> !valid3_reg)
        else $error("result word repeated on output");

    // An input word taken during an output stall needs a free stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && valid3_reg && out_stall) |-> !(valid0_reg && valid1_reg && valid2_reg))
        else $error("input accepted into a full pipeline");

endmodule

### src/pis_error_stage.sv
// ----------------------------------------------------------------------------
// pis_error_stage: input register, error and separated integral
// Holds the previous error and the saturating integral.
// ----------------------------------------------------------------------------
module pis_error_stage #(
    parameter int DATA_WIDTH = 16,
    parameter int SUM_WIDTH  = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_load,
    input  logic                                  calc_load,
    input  logic signed [DATA_WIDTH-1:0]          measured,
    input  logic signed [DATA_WIDTH-1:0]          setpoint,
    input  logic        [pis_pkg::GAIN_WIDTH-1:0] gain_i,
    input  logic        [pis_pkg::GAIN_WIDTH-1:0] separation_limit,
    output logic signed [DATA_WIDTH:0]            err,
    output logic signed [DATA_WIDTH+1:0]          diff,
    output logic signed [SUM_WIDTH-1:0]           error_sum
);

    localparam int ERR_WIDTH  = DATA_WIDTH + 1;
    localparam int DIFF_WIDTH = DATA_WIDTH + 2;
    localparam int EXT_WIDTH  = ((SUM_WIDTH > ERR_WIDTH) ? SUM_WIDTH : ERR_WIDTH) + 1;
    localparam int MAG_WIDTH  = (ERR_WIDTH > pis_pkg::GAIN_WIDTH) ? ERR_WIDTH
                                                                  : pis_pkg::GAIN_WIDTH;
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic signed [DATA_WIDTH-1:0] meas_reg;
    logic signed [DATA_WIDTH-1:0] setp_reg;
    logic signed [ERR_WIDTH-1:0]  err_reg;
    logic signed [ERR_WIDTH-1:0]  err_next;
    logic signed [DIFF_WIDTH-1:0] diff_reg;
    logic signed [DIFF_WIDTH-1:0] diff_next;
    logic signed [SUM_WIDTH-1:0]  sum_reg;
    logic signed [SUM_WIDTH-1:0]  sum_next;
    logic        [ERR_WIDTH-1:0]  mag;
    logic signed [EXT_WIDTH-1:0]  sum_ext;
    logic                         integrate;

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            meas_reg <= measured;
            setp_reg <= setpoint;
        end
    end

    assign err_next  = ERR_WIDTH'(setp_reg) - ERR_WIDTH'(meas_reg);
    assign diff_next = DIFF_WIDTH'(err_next) - DIFF_WIDTH'(err_reg);
    assign mag       = err_next[ERR_WIDTH-1] ? ERR_WIDTH'(-err_next) : ERR_WIDTH'(err_next);
    assign integrate = (gain_i != '0) && (MAG_WIDTH'(mag) < MAG_WIDTH'(separation_limit));
    assign sum_ext   = EXT_WIDTH'(sum_reg) + EXT_WIDTH'(err_next);

    // Integrate inside the separation band, saturating; clear outside it or when gain_i is zero.
    always_comb
    begin
        if (!integrate)
            sum_next = '0;
        else if (sum_ext > EXT_WIDTH'(SUM_MAX))
            sum_next = SUM_MAX;
        else if (sum_ext < EXT_WIDTH'(SUM_MIN))
            sum_next = SUM_MIN;
        else
            sum_next = sum_ext[SUM_WIDTH-1:0];
    end

    // err_reg doubles as the previous error for the next sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= '0;
            sum_reg <= '0;
        end
        else if (calc_load)
        begin
            err_reg <= err_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_load)
            diff_reg <= diff_next;
    end

    assign err       = err_reg;
    assign diff      = diff_reg;
    assign error_sum = sum_reg;

endmodule

### src/pis_mult_stage.sv
// ----------------------------------------------------------------------------
// pis_mult_stage: gain multipliers
// Registers the proportional, integral and derivative products.
// ----------------------------------------------------------------------------
module pis_mult_stage #(
    parameter int DATA_WIDTH = 16,
    parameter int SUM_WIDTH  = 32
) (
    input  logic                                                clk,
    input  logic                                                load,
    input  pis_pkg::cfg_t                                       cfg,
    input  logic signed [DATA_WIDTH:0]                          err,
    input  logic signed [DATA_WIDTH+1:0]                        diff,
    input  logic signed [SUM_WIDTH-1:0]                         error_sum,
    output logic signed [pis_pkg::GAIN_WIDTH+DATA_WIDTH+1:0]    prod_p,
    output logic signed [pis_pkg::GAIN_WIDTH+SUM_WIDTH:0]       prod_i,
    output logic signed [pis_pkg::GAIN_WIDTH+DATA_WIDTH+2:0]    prod_d
);

    localparam int P_WIDTH = pis_pkg::GAIN_WIDTH + DATA_WIDTH + 2;
    localparam int I_WIDTH = pis_pkg::GAIN_WIDTH + SUM_WIDTH + 1;
    localparam int D_WIDTH = pis_pkg::GAIN_WIDTH + DATA_WIDTH + 3;

    logic signed [P_WIDTH-1:0] prod_p_reg;
    logic signed [I_WIDTH-1:0] prod_i_reg;
    logic signed [D_WIDTH-1:0] prod_d_reg;
    logic signed [P_WIDTH-1:0] prod_p_next;
    logic signed [I_WIDTH-1:0] prod_i_next;
    logic signed [D_WIDTH-1:0] prod_d_next;

    // Gains are unsigned: prepend a zero bit to keep them positive.
    assign prod_p_next = P_WIDTH'($signed({1'b0, cfg.gain_p})) * P_WIDTH'(err);
    assign prod_i_next = I_WIDTH'($signed({1'b0, cfg.gain_i})) * I_WIDTH'(error_sum);
    assign prod_d_next = D_WIDTH'($signed({1'b0, cfg.gain_d})) * D_WIDTH'(diff);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
    end

    assign prod_p = prod_p_reg;
    assign prod_i = prod_i_reg;
    assign prod_d = prod_d_reg;

endmodule

### src/pis_output_stage.sv
// ----------------------------------------------------------------------------
// pis_output_stage: sum, scale and clamp
// Adds the three terms, drops the fraction bits and applies the limits.
// ----------------------------------------------------------------------------
module pis_output_stage #(
    parameter int DATA_WIDTH     = 16,
    parameter int SUM_WIDTH      = 32,
    parameter int GAIN_FRAC_BITS = 12
) (
    input  logic                                                clk,
    input  logic                                                load,
    input  pis_pkg::cfg_t                                       cfg,
    input  logic signed [pis_pkg::GAIN_WIDTH+DATA_WIDTH+1:0]    prod_p,
    input  logic signed [pis_pkg::GAIN_WIDTH+SUM_WIDTH:0]       prod_i,
    input  logic signed [pis_pkg::GAIN_WIDTH+DATA_WIDTH+2:0]    prod_d,
    output logic signed [pis_pkg::DRIVE_WIDTH-1:0]              drive,
    output logic                                                clamped
);

    localparam int I_WIDTH   = pis_pkg::GAIN_WIDTH + SUM_WIDTH + 1;
    localparam int D_WIDTH   = pis_pkg::GAIN_WIDTH + DATA_WIDTH + 3;
    localparam int ACC_WIDTH = ((I_WIDTH > D_WIDTH) ? I_WIDTH : D_WIDTH) + 2;

    logic signed [ACC_WIDTH-1:0]            acc;
    logic signed [ACC_WIDTH-1:0]            scaled;
    logic signed [ACC_WIDTH-1:0]            upper_cut;
    logic signed [ACC_WIDTH-1:0]            lower_cut;
    logic                                   over_max;
    logic                                   under_min;
    logic signed [pis_pkg::DRIVE_WIDTH-1:0] drive_reg;
    logic                                   clamped_reg;

    assign acc    = ACC_WIDTH'(prod_p) + ACC_WIDTH'(prod_i) + ACC_WIDTH'(prod_d);
    assign scaled = acc >>> GAIN_FRAC_BITS;

    // Upper limit first, then lower, so drive_min wins on inverted limits.
    assign over_max  = scaled > ACC_WIDTH'(cfg.drive_max);
    assign upper_cut = over_max ? ACC_WIDTH'(cfg.drive_max) : scaled;
    assign under_min = upper_cut < ACC_WIDTH'(cfg.drive_min);
    assign lower_cut = under_min ? ACC_WIDTH'(cfg.drive_min) : upper_cut;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg   <= lower_cut[pis_pkg::DRIVE_WIDTH-1:0];
            clamped_reg <= over_max || under_min;
        end
    end

    assign drive   = drive_reg;
    assign clamped = clamped_reg;

endmodule

### test/pid_integral_separation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_integral_separation_checker: drive word prediction and comparison
// Mirrors register writes, predicts one drive word per accepted input word
// and compares every accepted output word with the oldest prediction.
// ----------------------------------------------------------------------------
module pid_integral_separation_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [pis_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [pis_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic signed [15:0]                     measured,
    input  logic signed [15:0]                     setpoint,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic signed [pis_pkg::DRIVE_WIDTH-1:0] drive,
    input  logic                                   clamped,
    output int                                     mismatch_count,
    output int                                     words_pending
);
    localparam int     FRAC_BITS    = 12;
    localparam int     PRINT_LIMIT  = 100;
    localparam longint INTEGRAL_MAX = (longint'(1) <<< 31) - 1;
    localparam longint INTEGRAL_MIN = -(longint'(1) <<< 31);

    typedef struct packed {
        logic signed [pis_pkg::DRIVE_WIDTH-1:0] drive;
        logic                                   clamped;
    } drive_word_t;

    pis_pkg::cfg_t settings;
    longint        last_error;
    longint        integral;
    int            words_checked;
    drive_word_t   expected_drive_q[$];

    initial
    begin
        mismatch_count = 0;
        words_pending  = 0;
        words_checked  = 0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("%t  drive word %0d mismatch: %s", $time, words_checked, what);
        mismatch_count++;
    endtask

    // Advance the controller state by one sample and return its drive word.
    function automatic drive_word_t advance_controller(input longint meas, input longint setp);
        longint      err, mag, sep, gp, gi, gd, lo, hi, acc, level;
        drive_word_t word;
        err = setp - meas;
        mag = (err < 0) ? -err : err;
        sep = settings.separation_limit;
        gp  = settings.gain_p;
        gi  = settings.gain_i;
        gd  = settings.gain_d;
        lo  = $signed(settings.drive_min);
        hi  = $signed(settings.drive_max);
        if (gi != 0 && mag < sep)
        begin
            integral = integral + err;
            if (integral > INTEGRAL_MAX)
                integral = INTEGRAL_MAX;
            if (integral < INTEGRAL_MIN)
                integral = INTEGRAL_MIN;
        end
        else
        begin
            integral = 0;
        end
        acc   = gp * err + gi * integral + gd * (err - last_error);
        level = acc >>> FRAC_BITS;
        word.clamped = 1'b0;
        // upper clamp first, so an inverted pair leaves drive_min in place
        if (level > hi)
        begin
            level = hi;
            word.clamped = 1'b1;
        end
        if (level < lo)
        begin
            level = lo;
            word.clamped = 1'b1;
        end
        last_error = err;
        word.drive = level[15:0];
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_word_t want;
        if (!rst_n)
        begin
            settings   = pis_pkg::CFG_RESET;
            last_error = 0;
            integral   = 0;
            expected_drive_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pis_pkg::REG_GAIN_P:    settings.gain_p           = cfg_data;
                    pis_pkg::REG_GAIN_I:    settings.gain_i           = cfg_data;
                    pis_pkg::REG_GAIN_D:    settings.gain_d           = cfg_data;
                    pis_pkg::REG_SEP_LIMIT: settings.separation_limit = cfg_data;
                    pis_pkg::REG_DRIVE_MIN: settings.drive_min        = cfg_data;
                    pis_pkg::REG_DRIVE_MAX: settings.drive_max        = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_drive_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word, drive %0d", drive));
                end
                else
                begin
                    want = expected_drive_q.pop_front();
                    if (drive !== want.drive)
                        report_mismatch($sformatf("drive %0d, predicted %0d",
                                                  drive, want.drive));
                    if (clamped !== want.clamped)
                        report_mismatch($sformatf("clamped %b, predicted %b",
                                                  clamped, want.clamped));
                end
                words_checked++;
            end
            if (in_valid && !in_stall)
                expected_drive_q.push_back(advance_controller(measured, setpoint));
        end
        words_pending = expected_drive_q.size();
    end

endmodule

### test/pid_integral_separation_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_integral_separation_tb: stimulus and verdict for the PID controller
// Drives directed and random samples under several register settings,
// runs long integrations in both directions, and takes the verdict
// from the checker that sits beside the block.
// ----------------------------------------------------------------------------
module pid_integral_separation_tb;

    localparam int HALF_HIGH      = 6;
    localparam int HALF_LOW       = 6;
    localparam int RESET_CYCLES   = 4;
    // no handshake for this many cycles means the block is hung
    localparam int STUCK_LIMIT    = 400;
    // drain margin after the last word: pipeline is four stages deep
    localparam int LATENCY_PAD    = 8;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 204;
    // length of each long integration run at the largest integrating error
    localparam int SATURATE_WORDS = 60;
    localparam int PROBE_WORDS    = 40;

    // register indexes with no register behind them; writes must be dropped
    localparam logic [pis_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [pis_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

    logic                                   clk       = 1'b0;
    logic                                   rst_n     = 1'b0;
    logic                                   cfg_we    = 1'b0;
    logic [pis_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index = '0;
    logic [pis_pkg::CFG_DATA_WIDTH-1:0]     cfg_data  = '0;
    logic                                   in_valid  = 1'b0;
    logic                                   in_stall;
    logic signed [15:0]                     measured  = '0;
    logic signed [15:0]                     setpoint  = '0;
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic signed [pis_pkg::DRIVE_WIDTH-1:0] drive;
    logic                                   clamped;

    int            mismatch_count;
    int            words_pending;
    int            stuck_cycles = 0;
    int            stall_left   = 0;
    // high while neither side may idle
    bit            calm         = 1'b0;
    pis_pkg::cfg_t plan;

    always
    begin
        #HALF_HIGH clk = 1'b1;
        #HALF_LOW  clk = 1'b0;
    end

    pid_integral_separation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .measured  (measured),
        .setpoint  (setpoint),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive),
        .clamped   (clamped)
    );

    pid_integral_separation_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .measured       (measured),
        .setpoint       (setpoint),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .drive          (drive),
        .clamped        (clamped),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    // Receiver back-pressure: bursts of stalled cycles of random length, none while calm.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall = 1'b1;
        end
        else if (!calm && $urandom_range(0, 6) == 0)
        begin
            stall_left = $urandom_range(0, 10);
            out_stall  = 1'b1;
        end
        else
        begin
            out_stall = 1'b0;
        end
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("pid_integral_separation_tb: done, errors");
        $finish;
    end

    // Present one sample, after a random gap unless calm, and hold it until
    // the block takes it. Valid stays high on return so back-to-back words
    // follow without a gap.
    task automatic send_word(input logic signed [15:0] meas, input logic signed [15:0] setp);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap      = $urandom_range(1, 11);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        measured = meas;
        setpoint = setp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid and hold off until every predicted word has come back.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (words_pending != 0)
            @(negedge clk);
    endtask

    // One register write; call only while the block is drained.
    task automatic write_reg(input logic [pis_pkg::CFG_INDEX_WIDTH-1:0] index,
                             input logic [pis_pkg::CFG_DATA_WIDTH-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic load_settings(input pis_pkg::cfg_t c);
        write_reg(pis_pkg::REG_GAIN_P,    c.gain_p);
        write_reg(pis_pkg::REG_GAIN_I,    c.gain_i);
        write_reg(pis_pkg::REG_GAIN_D,    c.gain_d);
        write_reg(pis_pkg::REG_SEP_LIMIT, c.separation_limit);
        write_reg(pis_pkg::REG_DRIVE_MIN, c.drive_min);
        write_reg(pis_pkg::REG_DRIVE_MAX, c.drive_max);
    endtask

    function automatic logic [pis_pkg::GAIN_WIDTH-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return pis_pkg::GAIN_WIDTH'($urandom_range(0, 8191));
            default: return pis_pkg::GAIN_WIDTH'($urandom);
        endcase
    endfunction

    // Random settings: extremes now and then, mostly a sane window, sometimes
    // an inverted pair of limits.
    function automatic pis_pkg::cfg_t pick_settings();
        pis_pkg::cfg_t      c;
        logic signed [15:0] a;
        logic signed [15:0] b;
        c.gain_p = pick_gain();
        c.gain_i = pick_gain();
        c.gain_d = pick_gain();
        case ($urandom_range(0, 4))
            0:       c.separation_limit = '0;
            1:       c.separation_limit = '1;
            default: c.separation_limit = 16'($urandom_range(1, 300));
        endcase
        a = 16'($urandom);
        b = 16'($urandom);
        case ($urandom_range(0, 5))
            0:
            begin
                c.drive_min = 16'sh8000;
                c.drive_max = 16'sd32767;
            end
            1:
            begin
                c.drive_min = (a > b) ? a : b;
                c.drive_max = (a > b) ? b : a;
            end
            2:
            begin
                c.drive_min = -$signed(16'($urandom_range(0, 200)));
                c.drive_max = 16'($urandom_range(0, 200));
            end
            default:
            begin
                c.drive_min = (a > b) ? b : a;
                c.drive_max = (a > b) ? a : b;
            end
        endcase
        return c;
    endfunction

    // Mostly errors inside the separation window so the integral gets to
    // work; the rest sits on the window edge, at the field extremes, at zero
    // error, or is plain noise.
    task automatic send_random_word(input longint sep);
        logic signed [15:0] raw;
        longint             setp, meas, offset, span;
        int                 kind;
        kind = $urandom_range(0, 9);
        raw  = 16'($urandom);
        setp = raw;
        raw  = 16'($urandom);
        meas = raw;
        span = (sep > 1) ? sep - 1 : 0;
        case (kind)
            0, 1, 2, 3, 4, 5:
            begin
                offset = $urandom_range(0, int'(span));
                meas   = $urandom_range(0, 1) ? setp - offset : setp + offset;
            end
            6:
            begin
                offset = $urandom_range(0, 1) ? sep : span;
                meas   = $urandom_range(0, 1) ? setp - offset : setp + offset;
            end
            7: ;
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       setp = -32768;
                    1:       setp = 32767;
                    2:       setp = -1;
                    default: setp = 0;
                endcase
                case ($urandom_range(0, 3))
                    0:       meas = -32768;
                    1:       meas = 32767;
                    2:       meas = 1;
                    default: meas = 0;
                endcase
            end
            default: meas = setp;
        endcase
        if (meas > 32767)
            meas = 32767;
        if (meas < -32768)
            meas = -32768;
        send_word(16'(meas), 16'(setp));
    endtask

    initial
    begin
        pis_pkg::cfg_t c;

        // Hold reset, then release it away from the clock edge.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: integrate inside the window, clear on its edge,
        // negative error for floor rounding, then the widest errors.
        send_word(16'sd0, 16'sd0);
        send_word(16'sd0, 16'sd10);
        send_word(16'sd0, 16'sd14);
        send_word(16'sd0, 16'sd15);
        send_word(16'sd3, 16'sd0);
        send_word(16'sh8000, 16'sd32767);
        send_word(16'sd32767, 16'sh8000);
        send_word(-16'sd1, -16'sd1);

        // Writes to the spare indexes must leave every register alone;
        // a zero integral gain clears the integral on every sample.
        settle();
        write_reg(REG_SPARE_LO, 16'h0000);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        write_reg(pis_pkg::REG_GAIN_I, 16'h0000);
        send_word(16'sd0, 16'sd5);
        send_word(16'sd0, 16'sd5);

        // Inverted limits: drive_min wins and the flag is set.
        settle();
        write_reg(pis_pkg::REG_DRIVE_MIN, 16'sd100);
        write_reg(pis_pkg::REG_DRIVE_MAX, -16'sd100);
        send_word(16'sd0, 16'sd0);
        send_word(16'sh8000, 16'sd32767);

        // Every register at its top end, limits wide open.
        settle();
        c.gain_p           = '1;
        c.gain_i           = '1;
        c.gain_d           = '1;
        c.separation_limit = '1;
        c.drive_min        = 16'sh8000;
        c.drive_max        = 16'sd32767;
        load_settings(c);
        send_word(16'sh8000, 16'sd32767);
        send_word(16'sd32767, 16'sh8000);
        send_word(16'sd0, 16'sd1);
        send_word(16'sd0, -16'sd1);
        send_word(16'sd100, -16'sd100);

        // Every register at zero.
        settle();
        c = '0;
        load_settings(c);
        send_word(16'sd1234, -16'sd4321);

        // Long integration, positive side: pure integral at unit gain with
        // the largest error that still integrates, back to back.
        settle();
        calm               = 1'b1;
        c.gain_p           = '0;
        c.gain_i           = 16'd1;
        c.gain_d           = '0;
        c.separation_limit = '1;
        c.drive_min        = 16'sh8000;
        c.drive_max        = 16'sd32767;
        load_settings(c);
        repeat (SATURATE_WORDS) send_word(-16'sd32767, 16'sd32767);

        // Flip the error at a large proportional gain while the integral
        // unwinds.
        settle();
        write_reg(pis_pkg::REG_GAIN_P, 16'd32768);
        repeat (PROBE_WORDS) send_word(16'sd32767, -16'sd32767);

        // Clear with an error outside the window, then integrate negative and
        // flip back the same way.
        send_word(16'sd32767, 16'sh8000);
        repeat (SATURATE_WORDS) send_word(16'sd32767, -16'sd32767);
        repeat (PROBE_WORDS) send_word(-16'sd32767, 16'sd32767);
        calm = 1'b0;

        // Random phases, each under fresh settings written while drained.
        // One phase in the middle and the last one run without idling.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            plan = pick_settings();
            load_settings(plan);
            calm = (phase == PHASES / 2) || (phase == PHASES - 1);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // in phase 1 only, pause once mid-phase until the block has drained
                if (phase == 1 && n == PHASE_WORDS / 2)
                    settle();
                send_random_word(plan.separation_limit);
            end
        end

        settle();
        repeat (LATENCY_PAD) @(negedge clk);
        if (mismatch_count == 0)
            $display("pid_integral_separation_tb: done, clean");
        else
            $display("pid_integral_separation_tb: done, errors");
        $finish;
    end

endmodule
